@@ rtl/page_replacement_fifo_lru_macros.svh @@
// Assertion helpers, clocked on clock and quiet during reset.
`ifndef PAGE_REPLACEMENT_FIFO_LRU_MACROS_SVH
`define PAGE_REPLACEMENT_FIFO_LRU_MACROS_SVH

// Same-cycle implication.
`define PRFL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PRFL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/prfl_pkg.sv @@
package prfl_pkg;

   localparam int FRAMES    = 8;
   localparam int PAGE_BITS = 16;
   localparam int FIDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int FP2       = 1 << FIDX_W;
   localparam int STAMP_W   = 32;
   localparam int CNT_W     = 32;
   localparam int CFG_W     = 4;
   localparam int CSR_IDX_W = 1;

   // 2-entry queues on both sides
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY_MODE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_IN_USE = 1'd1;

   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   localparam logic CMD_REF   = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [15:0] page_number;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [2:0]  frame_index;
      logic        evicted_valid;
      logic [15:0] evicted_page;
      logic [31:0] fault_count;
      logic [31:0] reference_count;
   } rsp_type;

   // classified request handed from front to back
   typedef struct packed {
      logic                 is_clear;
      logic [PAGE_BITS-1:0] page;
   } op_type;

   // front queue status seen by the back end
   typedef struct packed {
      logic   valid;
      op_type op;
   } op_head_type;

   typedef struct packed {
      logic               valid;
      logic [STAMP_W-1:0] age;
      logic [FIDX_W-1:0]  idx;
   } node_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + CNT_W'(1);
   endfunction

endpackage

@@ rtl/page_replacement_fifo_lru.sv @@
// Page frame set with FIFO or LRU replacement.
// Request channel: a request {cmd, page_number} is taken when push is high and
// full is low; a 2-entry queue holds requests until the frame engine is free.
// Result channel: while empty is low the oldest result sits on rsp_data and is
// taken when pop is high. Every request, clear included, yields one result.
// CSR port: csr_wr_en writes csr_wdata to register csr_index (0 policy_mode,
// 1 frames_in_use); write only while no request is in flight.
// The frame engine takes a request from the queue only in EVAL and only while
// the result queue has room; EVAL compares all frames and forms stamp ages,
// EXEC picks the frame (hit, first empty, or oldest by a compare tree) and
// updates frames and counters, and no new request is taken before EXEC ends.
// Reset: frames empty, counters and stamp zero, FIFO mode, 8 frames in use.
// When pop is held low the result queue fills, the engine stops taking
// requests, and full rises once the request queue is full too; nothing is lost.
module page_replacement_fifo_lru
   import prfl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  req_type              req_data,
   output logic                 full,
   output logic                 empty,
   input  logic                 pop,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   op_head_type head;
   logic        op_pop;
   logic        rsp_full;
   logic        rsp_push;
   rsp_type     rsp_in;

   // request queue and decode
   prfl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .head     (head),
      .op_pop   (op_pop)
   );

   // frame engine: lookup, victim choice, counters, CSRs
   prfl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .head      (head),
      .op_pop    (op_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_in    (rsp_in)
   );

   // result queue decouples the engine from a stalled receiver
   prfl_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .rsp_push (rsp_push),
      .rsp_in   (rsp_in),
      .rsp_full (rsp_full),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

endmodule

@@ rtl/prfl_front.sv @@
`include "page_replacement_fifo_lru_macros.svh"

module prfl_front
   import prfl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  req_type     req_data,
   output logic        full,
   output op_head_type head,
   input  logic        op_pop
);

   op_type              slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;
   op_type              op_new;

   assign full    = (count_ff == QCNT_W'(QDEPTH));
   assign do_push = push && !full;
   assign do_pop  = op_pop && (count_ff != '0);

   // classify: clear or reference, page cast to the compared width
   always_comb begin
      op_new.is_clear = (req_data.cmd == CMD_CLEAR);
      op_new.page     = PAGE_BITS'(req_data.page_number);
   end

   assign head.valid = (count_ff != '0);
   assign head.op    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= op_new;
      end
   end

   `PRFL_ASSERT_NOW(a_front_bound, 1'b1, count_ff <= QCNT_W'(QDEPTH), "front queue overrun")

endmodule

@@ rtl/prfl_rsp_queue.sv @@
`include "page_replacement_fifo_lru_macros.svh"

module prfl_rsp_queue
   import prfl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    rsp_push,
   input  rsp_type rsp_in,
   output logic    rsp_full,
   input  logic    pop,
   output logic    empty,
   output rsp_type rsp_data
);

   rsp_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign rsp_full = (count_ff == QCNT_W'(QDEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = rsp_push && !rsp_full;
   assign do_pop   = pop && !empty;
   assign rsp_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= rsp_in;
      end
   end

   `PRFL_ASSERT_NOW(a_rsp_bound, 1'b1, count_ff <= QCNT_W'(QDEPTH), "result queue overrun")

endmodule

@@ rtl/prfl_back.sv @@
`include "page_replacement_fifo_lru_macros.svh"

module prfl_back
   import prfl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  op_head_type          head,
   output logic                 op_pop,
   input  logic                 rsp_full,
   output logic                 rsp_push,
   output rsp_type              rsp_in
);

   localparam logic ST_EVAL = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                  state_ff, state_in;
   logic                  policy_ff;
   logic [CFG_W-1:0]      fcfg_ff;

   logic [FRAMES-1:0]     frame_valid_ff;
   logic [PAGE_BITS-1:0]  frame_page_ff  [FRAMES];
   logic [STAMP_W-1:0]    frame_stamp_ff [FRAMES];
   logic [STAMP_W-1:0]    stamp_ctr_ff;
   logic [CNT_W-1:0]      faults_ff, faults_in;
   logic [CNT_W-1:0]      refs_ff, refs_in;

   // evaluation stage registers
   op_type                op_ff;
   logic [FRAMES-1:0]     hit_vec_ff, hit_vec_in;
   logic [FRAMES-1:0]     empty_vec_ff, empty_vec_in;
   logic [FRAMES-1:0]     act_ff, act_in;
   logic [STAMP_W-1:0]    age_ff [FRAMES];
   logic [STAMP_W-1:0]    age_in [FRAMES];

   logic                  start;
   logic                  hit_any, empty_any, evict;
   logic [FIDX_W-1:0]     hit_idx, empty_idx, slot;
   node_type              tree [1:2*FP2-1];

   assign start    = (state_ff == ST_EVAL) && head.valid && !rsp_full;
   assign op_pop   = start;
   assign rsp_push = (state_ff == ST_EXEC);

   always_comb begin
      unique case (state_ff)
         ST_EVAL: state_in = start ? ST_EXEC : ST_EVAL;
         ST_EXEC: state_in = ST_EVAL;
      endcase
   end

   // frame count 0 acts as 1, counts past FRAMES as FRAMES
   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         act_in[i]       = (i == 0) || (32'(fcfg_ff) > 32'(i));
         hit_vec_in[i]   = act_in[i] && frame_valid_ff[i] && (frame_page_ff[i] == head.op.page);
         empty_vec_in[i] = act_in[i] && !frame_valid_ff[i];
         age_in[i]       = stamp_ctr_ff - frame_stamp_ff[i];
      end
   end

   // oldest-stamp search, ties to the lower index
   always_comb begin
      node_type l, r;
      for (int k = 0; k < FP2; k++) begin
         if (k < FRAMES) begin
            tree[FP2+k] = '{valid: act_ff[k], age: age_ff[k], idx: FIDX_W'(k)};
         end else begin
            tree[FP2+k] = '0;
         end
      end
      for (int k = FP2 - 1; k >= 1; k--) begin
         l = tree[2*k];
         r = tree[2*k+1];
         tree[k] = (!r.valid || (l.valid && (l.age >= r.age))) ? l : r;
      end
   end

   always_comb begin
      hit_idx   = '0;
      empty_idx = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (hit_vec_ff[i]) begin
            hit_idx = FIDX_W'(i);
         end
         if (empty_vec_ff[i]) begin
            empty_idx = FIDX_W'(i);
         end
      end
      hit_any   = |hit_vec_ff;
      empty_any = |empty_vec_ff;
      evict     = !hit_any && !empty_any;
      slot      = hit_any ? hit_idx : (empty_any ? empty_idx : tree[1].idx);
      faults_in = hit_any ? faults_ff : sat_inc(faults_ff);
      refs_in   = sat_inc(refs_ff);
   end

   always_comb begin
      if (op_ff.is_clear) begin
         rsp_in = '0;
      end else begin
         rsp_in.hit             = hit_any;
         rsp_in.frame_index     = 3'(slot);
         rsp_in.evicted_valid   = evict;
         rsp_in.evicted_page    = evict ? 16'(frame_page_ff[slot]) : '0;
         rsp_in.fault_count     = 32'(faults_in);
         rsp_in.reference_count = 32'(refs_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_EVAL;
         policy_ff      <= POLICY_FIFO;
         fcfg_ff        <= CFG_W'(8);
         frame_valid_ff <= '0;
         stamp_ctr_ff   <= '0;
         faults_ff      <= '0;
         refs_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_POLICY_MODE:   policy_ff <= csr_wdata[0];
               CSR_FRAMES_IN_USE: fcfg_ff   <= csr_wdata;
            endcase
         end
         if (state_ff == ST_EXEC) begin
            if (op_ff.is_clear) begin
               frame_valid_ff <= '0;
               stamp_ctr_ff   <= '0;
               faults_ff      <= '0;
               refs_ff        <= '0;
            end else begin
               frame_valid_ff[slot] <= 1'b1;
               stamp_ctr_ff         <= stamp_ctr_ff + STAMP_W'(1);
               faults_ff            <= faults_in;
               refs_ff              <= refs_in;
            end
         end
      end
   end

   // payload: stamps of empty frames are never consulted, so no reset
   always_ff @(posedge clock) begin
      if (start) begin
         op_ff        <= head.op;
         hit_vec_ff   <= hit_vec_in;
         empty_vec_ff <= empty_vec_in;
         act_ff       <= act_in;
         age_ff       <= age_in;
      end
      if ((state_ff == ST_EXEC) && !op_ff.is_clear) begin
         if (!hit_any) begin
            frame_page_ff[slot]  <= op_ff.page;
            frame_stamp_ff[slot] <= stamp_ctr_ff;
         end else if (policy_ff == POLICY_LRU) begin
            frame_stamp_ff[slot] <= stamp_ctr_ff;
         end
      end
   end

   `PRFL_ASSERT_NOW(a_exec_room, state_ff == ST_EXEC, !rsp_full, "result pushed into full queue")
   `PRFL_ASSERT_NOW(a_hit_no_evict, rsp_push, !(rsp_in.hit && rsp_in.evicted_valid), "hit with eviction")
   `PRFL_ASSERT_NEXT(a_clear_empties, (state_ff == ST_EXEC) && op_ff.is_clear, frame_valid_ff == '0, "clear left frames valid")

endmodule

@@ verif/page_replacement_fifo_lru_test.sv @@
module page_replacement_fifo_lru_test;
   import prfl_pkg::*;

   // Hang guard: cycles with neither a request nor a result taken.
   // The longest legal lull is a pop stall plus a push gap,
   // or a CSR pause, so this is generous.
   localparam int IDLE_LIMIT   = 2000;
   // Settling time before a CSR write and at the end.
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS  = 100;

   // Tracks the frame set as the block should see it and queues the
   // outcome that each accepted request should produce.
   class page_frame_tracker;
      logic [15:0]      page_of[FRAMES];
      bit               valid_of[FRAMES];
      logic [31:0]      stamp_of[FRAMES];
      logic [31:0]      stamp_now;
      logic [31:0]      faults;
      logic [31:0]      references;
      logic             policy;
      logic [CFG_W-1:0] frames_cfg;
      rsp_type          expected_outcomes[$];
      int               mismatches;
      int               hits;
      int               misses;
      int               evictions;
      int               clears;

      function new();
         policy     = POLICY_FIFO;
         frames_cfg = CFG_W'(FRAMES);
         wipe();
      endfunction

      function void wipe();
         for (int i = 0; i < FRAMES; i++) begin
            valid_of[i] = 1'b0;
            stamp_of[i] = '0;
            page_of[i]  = '0;
         end
         stamp_now  = '0;
         faults     = '0;
         references = '0;
      endfunction

      function void set_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CFG_W-1:0] value);
         if (idx == CSR_POLICY_MODE)
            policy = value[0];
         else if (idx == CSR_FRAMES_IN_USE)
            frames_cfg = value;
      endfunction

      function void note_request(input req_type r);
         rsp_type     o;
         int          n;
         int          slot;
         int          i;
         bit          found;
         logic [31:0] age;
         logic [31:0] oldest;
         o = '0;
         if (r.cmd == CMD_CLEAR) begin
            wipe();
            clears++;
         end else begin
            // 0 behaves as 1 frame, anything above FRAMES as FRAMES
            n = (frames_cfg == 0) ? 1 :
                ((frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg));
            found = 1'b0;
            slot  = 0;
            for (i = 0; i < n; i++) begin
               if (!found && valid_of[i] && page_of[i] == r.page_number) begin
                  found = 1'b1;
                  slot  = i;
               end
            end
            if (found) begin
               o.hit = 1'b1;
               hits++;
               if (policy == POLICY_LRU)
                  stamp_of[slot] = stamp_now;
            end else begin
               for (i = 0; i < n; i++) begin
                  if (!found && !valid_of[i]) begin
                     found = 1'b1;
                     slot  = i;
                  end
               end
               if (!found) begin
                  // oldest by wrapping age, lowest index on a tie
                  slot   = 0;
                  oldest = stamp_now - stamp_of[0];
                  for (i = 1; i < n; i++) begin
                     age = stamp_now - stamp_of[i];
                     if (age > oldest) begin
                        oldest = age;
                        slot   = i;
                     end
                  end
                  o.evicted_valid = 1'b1;
                  o.evicted_page  = page_of[slot];
                  evictions++;
               end
               page_of[slot]  = r.page_number;
               valid_of[slot] = 1'b1;
               stamp_of[slot] = stamp_now;
               if (faults != '1)
                  faults++;
               misses++;
            end
            stamp_now++;
            if (references != '1)
               references++;
            o.frame_index     = 3'(slot);
            o.fault_count     = faults;
            o.reference_count = references;
         end
         expected_outcomes.push_back(o);
      endfunction

      function int pending();
         return expected_outcomes.size();
      endfunction

      function void compare_field(input string field, input logic [63:0] want,
                                  input logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_outcome(input rsp_type got);
         rsp_type want;
         if (expected_outcomes.size() == 0) begin
            $error("result popped with no request outstanding");
            mismatches++;
         end else begin
            want = expected_outcomes.pop_front();
            compare_field("hit", 64'(want.hit), 64'(got.hit));
            compare_field("frame_index", 64'(want.frame_index), 64'(got.frame_index));
            compare_field("evicted_valid", 64'(want.evicted_valid),
                          64'(got.evicted_valid));
            compare_field("evicted_page", 64'(want.evicted_page),
                          64'(got.evicted_page));
            compare_field("fault_count", 64'(want.fault_count), 64'(got.fault_count));
            compare_field("reference_count", 64'(want.reference_count),
                          64'(got.reference_count));
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 push;
   req_type              req_data;
   logic                 full;
   logic                 empty;
   logic                 pop;
   rsp_type              rsp_data;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   page_frame_tracker tracker;
   int idle_cycles    = 0;
   int requests_taken = 0;
   int settings_used  = 0;
   int burst_left     = 0;
   bit tx_calm        = 1'b0;
   bit moved;
   // pop pattern: periodic stalls, shaped by rx_period and rx_stall
   int rx_tick        = 0;
   int rx_period      = 1;
   int rx_stall       = 0;
   bit rx_calm        = 1'b0;

   page_replacement_fifo_lru uut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: periodic stall pattern, its period and stall redrawn at random
   // over the run; now and then a stretch with pop held high throughout.
   always @(negedge clock) begin
      if (rx_tick % 64 == 0) begin
         rx_calm   = ($urandom_range(0, 3) == 0);
         rx_period = $urandom_range(2, 40);
         rx_stall  = $urandom_range(0, (rx_period - 1 > 30) ? 30 : rx_period - 1);
      end
      pop <= rx_calm || ((rx_tick % rx_period) >= rx_stall);
      rx_tick++;
   end

   // Both handshakes are sampled here, before the block's own edge updates.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         moved = 1'b0;
         if (push && !full) begin
            tracker.note_request(req_data);
            requests_taken++;
            moved = 1'b1;
         end
         if (pop && !empty) begin
            tracker.check_outcome(rsp_data);
            moved = 1'b1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // One request; bursts of random length, with random gaps between them unless tx_calm.
   // Returns just after the edge at which the request was accepted.
   task automatic send_request(input logic cmd, input logic [15:0] page);
      req_type r;
      int      gap;
      r.cmd         = cmd;
      r.page_number = page;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if (!tx_calm) begin
            gap = $urandom_range(1, 12);
            push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      push     <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full)
         @(posedge clock);
   endtask

   // Stop pushing, let every outstanding result come back, then settle.
   task automatic wait_until_idle();
      @(negedge clock);
      push <= 1'b0;
      while (tracker.pending() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CFG_W-1:0] value);
      wait_until_idle();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      tracker.set_register(idx, value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Random phase: mostly pages from a small working set so that hits and
   // replacements both occur, some fully random pages, the odd clear.
   task automatic run_phase(input logic policy, input logic [CFG_W-1:0] frames,
                            input int count);
      logic [15:0] pool[16];
      int          pool_size;
      int          pick;
      write_register(CSR_POLICY_MODE, CFG_W'(policy));
      write_register(CSR_FRAMES_IN_USE, frames);
      settings_used++;
      tx_calm   = ($urandom_range(0, 3) == 0);
      pool_size = $urandom_range(2, 16);
      foreach (pool[k])
         pool[k] = 16'($urandom);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 3)
            send_request(CMD_CLEAR, 16'($urandom));
         else if (pick < 15)
            send_request(CMD_REF, 16'($urandom));
         else
            send_request(CMD_REF, pool[$urandom_range(0, pool_size - 1)]);
      end
   endtask

   initial begin
      clock     = 1'b0;
      reset     = 1'b1;
      push      = 1'b0;
      req_data  = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_POLICY_MODE;
      csr_wdata = '0;
      tracker   = new();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Directed, reset settings (FIFO, all 8 frames): fill from empty with
      // extreme page values, hit, then replace the oldest loads even though
      // one of them was just hit.
      send_request(CMD_REF, 16'h0000);
      send_request(CMD_REF, 16'hFFFF);
      send_request(CMD_REF, 16'h0000);
      send_request(CMD_REF, 16'h8000);
      send_request(CMD_REF, 16'h7FFF);
      send_request(CMD_REF, 16'h5555);
      send_request(CMD_REF, 16'hAAAA);
      send_request(CMD_REF, 16'h0001);
      send_request(CMD_REF, 16'hFFFE);
      send_request(CMD_REF, 16'h1234);
      send_request(CMD_REF, 16'hFFFF);
      send_request(CMD_REF, 16'h4321);
      // clear with a non-zero page, which must be ignored
      send_request(CMD_CLEAR, 16'hFFFF);
      send_request(CMD_REF, 16'hFFFF);
      settings_used++;

      // LRU over 3 frames: a hit refreshes the stamp and moves the victim
      write_register(CSR_POLICY_MODE, CFG_W'(POLICY_LRU));
      write_register(CSR_FRAMES_IN_USE, CFG_W'(3));
      settings_used++;
      send_request(CMD_REF, 16'hA000);
      send_request(CMD_REF, 16'h0B00);
      send_request(CMD_REF, 16'hFFFF);
      send_request(CMD_REF, 16'h00C0);
      send_request(CMD_REF, 16'h0B00);
      send_request(CMD_REF, 16'h000D);

      // frame count 0 acts as one frame
      write_register(CSR_FRAMES_IN_USE, CFG_W'(0));
      settings_used++;
      send_request(CMD_REF, 16'hFFFF);
      send_request(CMD_REF, 16'h1111);

      // frame count 15 acts as 8; frames beyond 3 were never filled here
      write_register(CSR_FRAMES_IN_USE, CFG_W'(15));
      settings_used++;
      send_request(CMD_REF, 16'h0B00);
      send_request(CMD_REF, 16'h2222);

      // Random phases, no clear between them, so frames outside a reduced
      // count keep stale pages that reappear when the count grows again.
      run_phase(POLICY_LRU,  CFG_W'(8),  PHASE_ITEMS);
      run_phase(POLICY_FIFO, CFG_W'(1),  PHASE_ITEMS);
      run_phase(POLICY_LRU,  CFG_W'(0),  PHASE_ITEMS);
      run_phase(POLICY_FIFO, CFG_W'(15), PHASE_ITEMS);
      run_phase(POLICY_LRU,  CFG_W'(2),  PHASE_ITEMS);
      run_phase(POLICY_FIFO, CFG_W'(5),  PHASE_ITEMS);
      run_phase(POLICY_LRU,  CFG_W'(9),  PHASE_ITEMS);
      run_phase(POLICY_FIFO, CFG_W'(8),  PHASE_ITEMS);

      wait_until_idle();

      $display("Covered %0d requests: %0d hits, %0d faults (%0d replacing), %0d clears",
               requests_taken, tracker.hits, tracker.misses, tracker.evictions,
               tracker.clears);
      $display("Both policies, %0d register settings, frame counts 0 to 15, stalls",
               settings_used);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/prfl_pkg.sv
rtl/prfl_front.sv
rtl/prfl_rsp_queue.sv
rtl/prfl_back.sv
rtl/page_replacement_fifo_lru.sv
verif/page_replacement_fifo_lru_test.sv
